/* rtl/lqbp_pkg.sv */
// ----------------------------------------------------------------------------
// lqbp_pkg
// Shared types and constants for the lever quantiser and bell pulser.
// ----------------------------------------------------------------------------
package lqbp_pkg;

   // default sizes
   localparam int unsigned MAX_POSITION = 15;
   localparam int unsigned MAX_PENDING  = 255;

   // field widths
   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned HYST_W    = 10;
   localparam int unsigned MS_W      = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned EXTRA_W   = 4;
   localparam int unsigned POS_OUT_W = 4;
   localparam int unsigned PEND_OUT_W = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // register reset values
   localparam logic [SAMPLE_W-1:0] LEFT_START_RST  = 12'd0;
   localparam logic [SAMPLE_W-1:0] LEFT_STEP_RST   = 12'd256;
   localparam logic [SAMPLE_W-1:0] RIGHT_START_RST = 12'd0;
   localparam logic [SAMPLE_W-1:0] RIGHT_STEP_RST  = 12'd256;
   localparam logic [HYST_W-1:0]   HYST_RST        = 10'd16;
   localparam logic [MS_W-1:0]     DOWN_MS_RST     = 16'd100;
   localparam logic [MS_W-1:0]     INTERVAL_MS_RST = 16'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_START  = 3'd0,
      CSR_LEFT_STEP   = 3'd1,
      CSR_RIGHT_START = 3'd2,
      CSR_RIGHT_STEP  = 3'd3,
      CSR_HYSTERESIS  = 3'd4,
      CSR_DOWN_MS     = 3'd5,
      CSR_INTERVAL_MS = 3'd6
   } csr_index_type;

   // lane status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } lane_stat_type;

endpackage

/* rtl/lqbp_lane.sv */
// ----------------------------------------------------------------------------
// lqbp_lane
// One lever lane: detent window check and iterative detent division.
// ----------------------------------------------------------------------------
module lqbp_lane #(
   parameter int unsigned MAX_POSITION = lqbp_pkg::MAX_POSITION,
   localparam int unsigned POS_W = $clog2(MAX_POSITION + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lqbp_pkg::SAMPLE_W-1:0]     sample,
   input  logic [lqbp_pkg::SAMPLE_W-1:0]     cfg_start,
   input  logic [lqbp_pkg::SAMPLE_W-1:0]     cfg_step,
   input  logic [lqbp_pkg::HYST_W-1:0]       cfg_hyst,
   output lqbp_pkg::lane_stat_type           stat,
   output logic [POS_W-1:0]                  detent,
   output logic [POS_W-1:0]                  delta
);

   localparam int unsigned SW     = lqbp_pkg::SAMPLE_W;
   localparam int unsigned PROD_W = POS_W + SW;
   localparam int unsigned CEN_W  = PROD_W + 1;
   localparam int unsigned CMP_W  = CEN_W + 2;
   localparam int unsigned NUM_W  = SW + 1;
   localparam int unsigned CNT_W  = $clog2(NUM_W);

   typedef enum logic [4:0] {
      L_IDLE = 5'b00001,
      L_CMP  = 5'b00010,
      L_DIV  = 5'b00100,
      L_FIN  = 5'b01000,
      L_DONE = 5'b10000
   } lane_state_type;

   lane_state_type      state_ff, state_in;
   logic [SW-1:0]       sample_ff, sample_in;
   logic [CEN_W-1:0]    centre_ff, centre_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    detent_ff, detent_in;
   logic [POS_W-1:0]    delta_ff, delta_in;

   logic [SW-1:0]       step_eff;
   logic [SW-1:0]       half;
   logic [PROD_W-1:0]   prod;
   logic [CMP_W-1:0]    upper;
   logic [CMP_W-1:0]    lower_probe;
   logic                moved;
   logic [NUM_W:0]      num_pos;
   logic                num_neg;
   logic [NUM_W-1:0]    num;
   logic [NUM_W-1:0]    rem_sh;
   logic                fits;
   logic [POS_W-1:0]    newpos;

   // a zero step register behaves as one
   assign step_eff = (cfg_step == '0) ? SW'(1) : cfg_step;
   assign half     = step_eff >> 1;
   assign prod     = PROD_W'(detent_ff) * PROD_W'(step_eff);

   // window edges, both sides kept non-negative
   assign upper       = CMP_W'(centre_ff) + CMP_W'(half) + CMP_W'(cfg_hyst);
   assign lower_probe = CMP_W'(sample_ff) + CMP_W'(half) + CMP_W'(cfg_hyst);
   assign moved       = (CMP_W'(sample_ff) > upper) || (lower_probe < CMP_W'(centre_ff));

   assign num_pos = (NUM_W + 1)'(sample_ff) + (NUM_W + 1)'(half);
   assign num_neg = num_pos < (NUM_W + 1)'(cfg_start);
   assign num     = NUM_W'(num_pos - (NUM_W + 1)'(cfg_start));

   // restoring division, one quotient bit a cycle
   assign rem_sh = {rem_ff[NUM_W-2:0], quo_ff[NUM_W-1]};
   assign fits   = rem_sh >= NUM_W'(step_eff);

   assign newpos = (quo_ff > NUM_W'(MAX_POSITION)) ? POS_W'(MAX_POSITION)
                                                   : POS_W'(quo_ff);

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      centre_in = centre_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      detent_in = detent_ff;
      delta_in  = delta_ff;
      case (state_ff)
         L_IDLE, L_DONE: begin
            if (start) begin
               sample_in = sample;
               centre_in = CEN_W'(prod) + CEN_W'(cfg_start);
               state_in  = L_CMP;
            end
         end
         L_CMP: begin
            if (!moved) begin
               delta_in = '0;
               state_in = L_DONE;
            end else if (num_neg) begin
               quo_in   = '0;
               state_in = L_FIN;
            end else begin
               quo_in   = num;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            rem_in = fits ? (rem_sh - NUM_W'(step_eff)) : rem_sh;
            quo_in = {quo_ff[NUM_W-2:0], fits};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = L_FIN;
            end
         end
         L_FIN: begin
            detent_in = newpos;
            delta_in  = (newpos > detent_ff) ? (newpos - detent_ff) : (detent_ff - newpos);
            state_in  = L_DONE;
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         detent_ff <= '0;
         delta_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         detent_ff <= detent_in;
         delta_ff  <= delta_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      centre_ff <= centre_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
   end

   assign stat.done = (state_ff == L_DONE);
   assign stat.busy = (state_ff != L_DONE) && (state_ff != L_IDLE);
   assign detent    = detent_ff;
   assign delta     = delta_ff;

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == L_DIV) |-> (cnt_ff < CNT_W'(NUM_W)))
      else $error("divider ran past its last quotient bit");

endmodule

/* rtl/lqbp_merge.sv */
// ----------------------------------------------------------------------------
// lqbp_merge
// Combines lane results: ring queue update, mute and bell plunger timing.
// ----------------------------------------------------------------------------
module lqbp_merge #(
   parameter int unsigned MAX_POSITION = lqbp_pkg::MAX_POSITION,
   parameter int unsigned MAX_PENDING  = lqbp_pkg::MAX_PENDING,
   localparam int unsigned POS_W  = $clog2(MAX_POSITION + 1),
   localparam int unsigned PEND_W = $clog2(MAX_PENDING + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             commit,
   input  logic [lqbp_pkg::EXTRA_W-1:0]     extra,
   input  logic                             mute,
   input  logic [lqbp_pkg::TIME_W-1:0]      now,
   input  logic [POS_W-1:0]                 delta_left,
   input  logic [POS_W-1:0]                 delta_right,
   input  logic [lqbp_pkg::MS_W-1:0]        cfg_down,
   input  logic [lqbp_pkg::MS_W-1:0]        cfg_interval,
   output logic [PEND_W-1:0]                pending,
   output logic                             bell
);

   localparam int unsigned BASE_W = (PEND_W > POS_W + 1) ?
                                    ((PEND_W > lqbp_pkg::EXTRA_W) ? PEND_W : lqbp_pkg::EXTRA_W) :
                                    ((POS_W + 1 > lqbp_pkg::EXTRA_W) ? POS_W + 1
                                                                      : lqbp_pkg::EXTRA_W);
   localparam int unsigned SUM_W  = BASE_W + 2;
   localparam int unsigned TW     = lqbp_pkg::TIME_W;

   logic [PEND_W-1:0] count_ff, count_in;
   logic              ext_ff, ext_in;
   logic [TW-1:0]     last_ff, last_in;

   logic [SUM_W-1:0]  sum;
   logic [PEND_W-1:0] queued;
   logic [TW-1:0]     elapsed;

   // saturating each addition in turn equals saturating the total
   assign sum = SUM_W'(count_ff) + SUM_W'(extra) + SUM_W'(delta_left) + SUM_W'(delta_right);

   always_comb begin
      if (mute) begin
         queued = '0;
      end else if (sum > SUM_W'(MAX_PENDING)) begin
         queued = PEND_W'(MAX_PENDING);
      end else begin
         queued = PEND_W'(sum);
      end
   end

   // wrapping time difference
   assign elapsed = now - last_ff;

   always_comb begin
      count_in = count_ff;
      ext_in   = ext_ff;
      last_in  = last_ff;
      if (commit) begin
         count_in = queued;
         if (ext_ff && (elapsed > TW'(cfg_down))) begin
            ext_in = 1'b0;
         end else if ((queued != '0) && (elapsed > TW'(cfg_interval))) begin
            ext_in   = 1'b1;
            last_in  = now;
            count_in = queued - PEND_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ext_ff   <= 1'b0;
         last_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ext_ff   <= ext_in;
         last_ff  <= last_in;
      end
   end

   assign pending = count_ff;
   assign bell    = ext_ff;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      PEND_W'(MAX_PENDING) >= count_ff)
      else $error("ring queue above its limit");

endmodule

/* rtl/lever_quantizer_bell_pulser.sv */
// ----------------------------------------------------------------------------
// lever_quantizer_bell_pulser
// Two lever lanes quantise ADC samples to detents; a merge stage queues
// bell rings and times the plunger pulse.
// ----------------------------------------------------------------------------
// sequence: the lanes check the detent window, run the divider only for a lever
//   that left its window and is not below its start, then the merge step commits
// one request at a time: a new request is taken only once the last has committed
// a finished result waits in the output register while the next request runs
// reset: synchronous, active high; registers take their documented defaults,
//   detents, ring queue, plunger and last ring time clear; no clearing pass
module lever_quantizer_bell_pulser #(
   parameter int unsigned MAX_POSITION = lqbp_pkg::MAX_POSITION,
   parameter int unsigned MAX_PENDING  = lqbp_pkg::MAX_PENDING
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lqbp_pkg::SAMPLE_W-1:0]       req_left_sample,
   input  logic [lqbp_pkg::SAMPLE_W-1:0]       req_right_sample,
   input  logic                                req_mute,
   input  logic [lqbp_pkg::EXTRA_W-1:0]        req_extra_rings,
   input  logic [lqbp_pkg::TIME_W-1:0]         req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lqbp_pkg::POS_OUT_W-1:0]      rsp_left_position,
   output logic [lqbp_pkg::POS_OUT_W-1:0]      rsp_right_position,
   output logic                                rsp_bell_drive,
   output logic [lqbp_pkg::PEND_OUT_W-1:0]     rsp_pending_rings,
   input  logic                                csr_wr_en,
   input  logic [lqbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lqbp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int unsigned POS_W  = $clog2(MAX_POSITION + 1);
   localparam int unsigned PEND_W = $clog2(MAX_PENDING + 1);
   localparam int unsigned SW     = lqbp_pkg::SAMPLE_W;
   localparam int unsigned OW     = lqbp_pkg::POS_OUT_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_LANE  = 3'b010,
      S_MERGE = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] left_pos_ff, left_pos_in;
   logic [OW-1:0] right_pos_ff, right_pos_in;

   // request fields held for the merge stage
   logic                             mute_ff, mute_in;
   logic [lqbp_pkg::EXTRA_W-1:0]     extra_ff, extra_in;
   logic [lqbp_pkg::TIME_W-1:0]      now_ff, now_in;

   // configuration registers
   logic [SW-1:0]                left_start_ff, left_start_in;
   logic [SW-1:0]                left_step_ff, left_step_in;
   logic [SW-1:0]                right_start_ff, right_start_in;
   logic [SW-1:0]                right_step_ff, right_step_in;
   logic [lqbp_pkg::HYST_W-1:0]  hyst_ff, hyst_in;
   logic [lqbp_pkg::MS_W-1:0]    down_ff, down_in;
   logic [lqbp_pkg::MS_W-1:0]    interval_ff, interval_in;

   logic                     accept;
   logic                     commit;
   lqbp_pkg::lane_stat_type  left_stat, right_stat;
   logic [POS_W-1:0]         left_detent, right_detent;
   logic [POS_W-1:0]         left_delta, right_delta;
   logic [PEND_W-1:0]        pending;
   logic                     bell;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == S_MERGE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      left_start_in  = left_start_ff;
      left_step_in   = left_step_ff;
      right_start_in = right_start_ff;
      right_step_in  = right_step_ff;
      hyst_in        = hyst_ff;
      down_in        = down_ff;
      interval_in    = interval_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lqbp_pkg::CSR_LEFT_START:  left_start_in  = csr_wr_data[SW-1:0];
            lqbp_pkg::CSR_LEFT_STEP:   left_step_in   = csr_wr_data[SW-1:0];
            lqbp_pkg::CSR_RIGHT_START: right_start_in = csr_wr_data[SW-1:0];
            lqbp_pkg::CSR_RIGHT_STEP:  right_step_in  = csr_wr_data[SW-1:0];
            lqbp_pkg::CSR_HYSTERESIS:  hyst_in        = csr_wr_data[lqbp_pkg::HYST_W-1:0];
            lqbp_pkg::CSR_DOWN_MS:     down_in        = csr_wr_data[lqbp_pkg::MS_W-1:0];
            lqbp_pkg::CSR_INTERVAL_MS: interval_in    = csr_wr_data[lqbp_pkg::MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      left_pos_in  = left_pos_ff;
      right_pos_in = right_pos_ff;
      mute_in      = mute_ff;
      extra_in     = extra_ff;
      now_in       = now_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mute_in  = req_mute;
               extra_in = req_extra_rings;
               now_in   = req_now_ms;
               state_in = S_LANE;
            end
         end
         S_LANE: begin
            if (left_stat.done && right_stat.done) begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               left_pos_in  = OW'(left_detent);
               right_pos_in = OW'(right_detent);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         left_start_ff  <= lqbp_pkg::LEFT_START_RST;
         left_step_ff   <= lqbp_pkg::LEFT_STEP_RST;
         right_start_ff <= lqbp_pkg::RIGHT_START_RST;
         right_step_ff  <= lqbp_pkg::RIGHT_STEP_RST;
         hyst_ff        <= lqbp_pkg::HYST_RST;
         down_ff        <= lqbp_pkg::DOWN_MS_RST;
         interval_ff    <= lqbp_pkg::INTERVAL_MS_RST;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         left_start_ff  <= left_start_in;
         left_step_ff   <= left_step_in;
         right_start_ff <= right_start_in;
         right_step_ff  <= right_step_in;
         hyst_ff        <= hyst_in;
         down_ff        <= down_in;
         interval_ff    <= interval_in;
      end
   end

   always_ff @(posedge clock) begin
      left_pos_ff  <= left_pos_in;
      right_pos_ff <= right_pos_in;
      mute_ff      <= mute_in;
      extra_ff     <= extra_in;
      now_ff       <= now_in;
   end

   lqbp_lane #(
      .MAX_POSITION (MAX_POSITION)
   ) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .sample    (req_left_sample),
      .cfg_start (left_start_ff),
      .cfg_step  (left_step_ff),
      .cfg_hyst  (hyst_ff),
      .stat      (left_stat),
      .detent    (left_detent),
      .delta     (left_delta)
   );

   lqbp_lane #(
      .MAX_POSITION (MAX_POSITION)
   ) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .sample    (req_right_sample),
      .cfg_start (right_start_ff),
      .cfg_step  (right_step_ff),
      .cfg_hyst  (hyst_ff),
      .stat      (right_stat),
      .detent    (right_detent),
      .delta     (right_delta)
   );

   lqbp_merge #(
      .MAX_POSITION (MAX_POSITION),
      .MAX_PENDING  (MAX_PENDING)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .extra        (extra_ff),
      .mute         (mute_ff),
      .now          (now_ff),
      .delta_left   (left_delta),
      .delta_right  (right_delta),
      .cfg_down     (down_ff),
      .cfg_interval (interval_ff),
      .pending      (pending),
      .bell         (bell)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_position  = left_pos_ff;
   assign rsp_right_position = right_pos_ff;
   assign rsp_bell_drive     = bell;
   assign rsp_pending_rings  = lqbp_pkg::PEND_OUT_W'(pending);

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LANE))
      else $error("request taken without starting the lanes");

   a_idle_lanes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!left_stat.busy && !right_stat.busy))
      else $error("lane still busy while sequencer idle");

   a_result_from_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_MERGE))
      else $error("result raised outside the merge step");

endmodule

/* tb/lqbp_checker.sv */
// ----------------------------------------------------------------------------
// lqbp_checker
// Watches the request, result and register ports of the lever quantiser and
// bell pulser, predicts each result from its own copy of detents, ring count
// and plunger timing, and compares every result field in order.
// ----------------------------------------------------------------------------
module lqbp_checker import lqbp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_left_sample,
   input  logic [SAMPLE_W-1:0]    req_right_sample,
   input  logic                   req_mute,
   input  logic [EXTRA_W-1:0]     req_extra_rings,
   input  logic [TIME_W-1:0]      req_now_ms,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [POS_OUT_W-1:0]   rsp_left_position,
   input  logic [POS_OUT_W-1:0]   rsp_right_position,
   input  logic                   rsp_bell_drive,
   input  logic [PEND_OUT_W-1:0]  rsp_pending_rings,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                     fail_count,
   output int                     open_count,
   output int                     checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [POS_OUT_W-1:0]  left_pos;
      logic [POS_OUT_W-1:0]  right_pos;
      logic                  bell;
      logic [PEND_OUT_W-1:0] pending;
   } bell_status_type;

   bell_status_type status_q[$];

   // register copies
   logic [SAMPLE_W-1:0] l_start, l_step, r_start, r_step;
   logic [HYST_W-1:0]   hyst;
   logic [MS_W-1:0]     down_ms, gap_ms;

   // predicted state
   int unsigned         lever_l, lever_r, ring_backlog;
   logic                plunger_out;
   logic [TIME_W-1:0]   last_start_ms;

   int fails   = 0;
   int checked = 0;

   function automatic int unsigned saturate_rings(input int unsigned backlog,
                                                  input int unsigned n);
      int unsigned sum;
      sum = backlog + n;
      if (n > MAX_PENDING || sum > MAX_PENDING) sum = MAX_PENDING;
      return sum;
   endfunction

   function automatic int unsigned next_detent(input int unsigned detent,
                                               input logic [SAMPLE_W-1:0] sample,
                                               input logic [SAMPLE_W-1:0] start,
                                               input logic [SAMPLE_W-1:0] step_reg,
                                               input logic [HYST_W-1:0] margin,
                                               output int unsigned moved);
      longint step_l, centre, half, num, pos, s;
      step_l = (step_reg == '0) ? 64'sd1 : longint'(step_reg);
      s      = longint'(sample);
      centre = longint'(detent) * step_l + longint'(start);
      half   = step_l / 2;
      moved  = 0;
      // window is half a step each side plus the margin, no wrapping
      if (s > centre + half + longint'(margin) || s < centre - half - longint'(margin)) begin
         num = s - longint'(start) + half;
         pos = (num < 0) ? 64'sd0 : num / step_l;
         if (pos > longint'(MAX_POSITION)) pos = longint'(MAX_POSITION);
         if (pos > longint'(detent)) moved = 32'(pos - longint'(detent));
         else moved = 32'(longint'(detent) - pos);
         return 32'(pos);
      end
      return detent;
   endfunction

   // one update: extra rings, left lever, right lever, mute, plunger
   function automatic bell_status_type settle_and_ring(input logic [SAMPLE_W-1:0] lsamp,
                                                       input logic [SAMPLE_W-1:0] rsamp,
                                                       input logic mute,
                                                       input logic [EXTRA_W-1:0] extra,
                                                       input logic [TIME_W-1:0] now);
      int unsigned       moved;
      logic [TIME_W-1:0] elapsed;
      bell_status_type   s;
      ring_backlog = saturate_rings(ring_backlog, extra);
      lever_l = next_detent(lever_l, lsamp, l_start, l_step, hyst, moved);
      ring_backlog = saturate_rings(ring_backlog, moved);
      lever_r = next_detent(lever_r, rsamp, r_start, r_step, hyst, moved);
      ring_backlog = saturate_rings(ring_backlog, moved);
      if (mute) ring_backlog = 0;
      elapsed = now - last_start_ms;
      // a due release wins over a new ring start
      if (plunger_out && elapsed > down_ms) begin
         plunger_out = 1'b0;
      end else if (ring_backlog > 0 && elapsed > gap_ms) begin
         last_start_ms = now;
         plunger_out   = 1'b1;
         ring_backlog--;
      end
      s.left_pos  = lever_l[POS_OUT_W-1:0];
      s.right_pos = lever_r[POS_OUT_W-1:0];
      s.bell      = plunger_out;
      s.pending   = ring_backlog[PEND_OUT_W-1:0];
      return s;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         fails++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      bell_status_type exp_s;
      if (reset) begin
         l_start       = LEFT_START_RST;
         l_step        = LEFT_STEP_RST;
         r_start       = RIGHT_START_RST;
         r_step        = RIGHT_STEP_RST;
         hyst          = HYST_RST;
         down_ms       = DOWN_MS_RST;
         gap_ms        = INTERVAL_MS_RST;
         lever_l       = 0;
         lever_r       = 0;
         ring_backlog  = 0;
         plunger_out   = 1'b0;
         last_start_ms = '0;
         status_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEFT_START:  l_start = csr_wr_data[SAMPLE_W-1:0];
               CSR_LEFT_STEP:   l_step  = csr_wr_data[SAMPLE_W-1:0];
               CSR_RIGHT_START: r_start = csr_wr_data[SAMPLE_W-1:0];
               CSR_RIGHT_STEP:  r_step  = csr_wr_data[SAMPLE_W-1:0];
               CSR_HYSTERESIS:  hyst    = csr_wr_data[HYST_W-1:0];
               CSR_DOWN_MS:     down_ms = csr_wr_data[MS_W-1:0];
               CSR_INTERVAL_MS: gap_ms  = csr_wr_data[MS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            status_q.push_back(settle_and_ring(req_left_sample, req_right_sample, req_mute,
                                               req_extra_rings, req_now_ms));
         if (rsp_valid && !rsp_stall) begin
            if (status_q.size() == 0) begin
               fails++;
               $display("%0t ns: result with no request outstanding, expected none,", $time,
                        " actual %0d %0d %0d %0d", rsp_left_position, rsp_right_position,
                        rsp_bell_drive, rsp_pending_rings);
            end else begin
               exp_s = status_q.pop_front();
               checked++;
               check_field("left_position", exp_s.left_pos, rsp_left_position);
               check_field("right_position", exp_s.right_pos, rsp_right_position);
               check_field("bell_drive", exp_s.bell, rsp_bell_drive);
               check_field("pending_rings", exp_s.pending, rsp_pending_rings);
            end
         end
      end
      open_count    <= status_q.size();
      fail_count    <= fails;
      checked_count <= checked;
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives lever samples, mute, ring requests and time stamps into the lever
// quantiser and bell pulser under bursty requests and random result stalls,
// reprograms the registers between phases and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lqbp_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_OFF    = 400;
   localparam int PHASE_ITEMS = 180;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_left_sample;
   logic [SAMPLE_W-1:0]    req_right_sample;
   logic                   req_mute;
   logic [EXTRA_W-1:0]     req_extra_rings;
   logic [TIME_W-1:0]      req_now_ms;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [POS_OUT_W-1:0]   rsp_left_position;
   logic [POS_OUT_W-1:0]   rsp_right_position;
   logic                   rsp_bell_drive;
   logic [PEND_OUT_W-1:0]  rsp_pending_rings;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int fail_count, open_count, checked_count;
   int burst_left     = 0;
   int sent_count     = 0;
   int settings_count = 1;
   bit flood_go       = 1'b0;

   lever_quantizer_bell_pulser uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_mute           (req_mute),
      .req_extra_rings    (req_extra_rings),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_position  (rsp_left_position),
      .rsp_right_position (rsp_right_position),
      .rsp_bell_drive     (rsp_bell_drive),
      .rsp_pending_rings  (rsp_pending_rings),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   lqbp_checker bell_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_mute           (req_mute),
      .req_extra_rings    (req_extra_rings),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_position  (rsp_left_position),
      .rsp_right_position (rsp_right_position),
      .rsp_bell_drive     (rsp_bell_drive),
      .rsp_pending_rings  (rsp_pending_rings),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .open_count         (open_count),
      .checked_count      (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic load_settings(input int unsigned ls, input int unsigned lst,
                                input int unsigned rs, input int unsigned rst,
                                input int unsigned hy, input int unsigned dn,
                                input int unsigned iv);
      logic [CSR_DATA_W-1:0] vals [7];
      csr_index_type         idx;
      vals = '{ls, lst, rs, rst, hy, dn, iv};
      idx  = idx.first();
      repeat (7) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= idx;
         csr_wr_data <= vals[idx];
         @(posedge clock);
         idx = idx.next();
      end
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   // one request, with a random gap whenever the current burst runs out
   task automatic offer(input logic [SAMPLE_W-1:0] ls, input logic [SAMPLE_W-1:0] rs,
                        input logic m, input logic [EXTRA_W-1:0] x,
                        input logic [TIME_W-1:0] t);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_left_sample  <= ls;
      req_right_sample <= rs;
      req_mute         <= m;
      req_extra_rings  <= x;
      req_now_ms       <= t;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic drain(input int tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // sample scattered around a wanted detent, sometimes anywhere on the scale
   function automatic logic [SAMPLE_W-1:0] lever_sample(input int unsigned start,
                                                        input int unsigned step_reg,
                                                        input int unsigned detent,
                                                        input int unsigned hy);
      int step_e, centre, span, s;
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
      step_e = (step_reg == 0) ? 1 : step_reg;
      centre = start + detent * step_e;
      span   = step_e / 2 + hy + 4;
      s      = centre + $urandom_range(0, 2 * span) - span;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      return s[SAMPLE_W-1:0];
   endfunction

   // result side back-pressure, with one long hold-off once flooding starts
   initial begin
      int  mode, span;
      bit  held;
      held = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (flood_go && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("%0t ns: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [TIME_W-1:0] wall;
      int unsigned       ls, lst, rs, rst, hy, dn, iv, lwant, rwant, dt;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_left_sample  <= '0;
      req_right_sample <= '0;
      req_mute         <= 1'b0;
      req_extra_rings  <= '0;
      req_now_ms       <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_LEFT_START;
      csr_wr_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers: full scale clamp, window edges, pulse timing, wrap, mute
      offer(0, 0, 1'b0, 0, 0);
      offer(4095, 4095, 1'b0, 0, 10);
      offer(3696, 3696, 1'b0, 0, 20);
      offer(3695, 4095, 1'b0, 1, 30);
      offer(1790, 3984, 1'b0, 0, 501);
      offer(1790, 3984, 1'b0, 0, 601);
      offer(1790, 3985, 1'b0, 0, 602);
      offer(1790, 3985, 1'b0, 0, 1102);
      offer(1790, 3985, 1'b0, 0, 32'hFFFF_FE00);
      offer(1790, 3985, 1'b0, 0, 32'hFFFF_FF00);
      offer(1790, 3985, 1'b0, 0, 32'h0000_0010);
      offer(1790, 3985, 1'b0, 0, 32'h0000_01F5);
      offer(1790, 3985, 1'b1, 15, 32'h0000_01F6);
      offer(1790, 3985, 1'b0, 15, 32'h0000_01F7);
      drain(3);

      // zero step, start above the sample, no margin, ring queue filling up
      load_settings(0, 0, 4095, 4095, 0, 0, 65535);
      for (int i = 0; i < 9; i++)
         offer((i % 2) ? 12'd0 : 12'd4095, (i % 2) ? 12'd4095 : 12'd0, 1'b0, 15, 32'h200);
      offer(4095, 0, 1'b1, 0, 32'h200);
      drain(3);

      for (int p = 0; p < 6; p++) begin
         case (p)
            2: begin
               ls = 0; lst = 4095; rs = 4095; rst = 1; hy = 1023; dn = 65535; iv = 65535;
            end
            3: begin
               ls  = $urandom_range(0, 200);
               lst = $urandom_range(1, 40);
               rs  = $urandom_range(0, 200);
               rst = $urandom_range(1, 40);
               hy = 0; dn = 0; iv = 0;
            end
            4: begin
               ls  = $urandom_range(0, 4095);
               lst = $urandom_range(0, 4095);
               rs  = $urandom_range(0, 4095);
               rst = $urandom_range(0, 4095);
               hy  = $urandom_range(0, 1023);
               dn  = $urandom_range(0, 65535);
               iv  = $urandom_range(0, 65535);
            end
            default: begin
               ls  = $urandom_range(0, 600);
               lst = $urandom_range(120, 300);
               rs  = $urandom_range(0, 600);
               rst = $urandom_range(120, 300);
               hy  = $urandom_range(0, 40);
               dn  = $urandom_range(20, 200);
               iv  = $urandom_range(dn, 600);
            end
         endcase
         load_settings(ls, lst, rs, rst, hy, dn, iv);
         if (p == 1) flood_go = 1'b1;
         wall  = $urandom;
         lwant = 0;
         rwant = 0;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0) lwant = $urandom_range(0, MAX_POSITION);
            if ($urandom_range(0, 5) == 0) rwant = $urandom_range(0, MAX_POSITION);
            // mostly small time steps, now and then a jump anywhere on the clock
            dt   = ($urandom_range(0, 24) == 0) ? $urandom : $urandom_range(0, (iv + dn) / 3 + 30);
            wall = wall + dt;
            offer(lever_sample(ls, lst, lwant, hy), lever_sample(rs, rst, rwant, hy),
                  ($urandom_range(0, 19) == 0),
                  ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : 0, wall);
         end
         drain(3);
      end

      drain(30);
      $display("%0d requests under %0d register settings, %0d results compared",
               sent_count, settings_count, checked_count);
      $display("levers swept over all detents with clamping, muting, ring saturation, "
               , "time wrap and a long result hold-off");
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
